/* rtl/ieqd_pkg.sv */
// Shared constants, types and lookup functions for the input event queue device.
`timescale 1ns / 1ps
package ieqd_pkg;

  // Ring and window geometry
  localparam int RING_WORDS   = 768;
  localparam int WINDOW_BYTES = 4096;
  localparam int RING_AW      = $clog2(RING_WORDS);
  localparam int RING_CW      = $clog2(RING_WORDS + 1);
  localparam int WIN_SUM_W    = $clog2(WINDOW_BYTES + 8) + 1;

  // Field widths
  localparam int OP_W   = 3;
  localparam int ADDR_W = 12;
  localparam int SIZE_W = 3;
  localparam int DATA_W = 32;
  localparam int KIDX_W = 6;
  localparam int WORD_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_KEY    = 3'd2;
  localparam logic [OP_W-1:0] OP_BUTTON = 3'd3;
  localparam logic [OP_W-1:0] OP_ABS    = 3'd4;
  localparam logic [OP_W-1:0] OP_SYNC   = 3'd5;

  // Bus register offsets
  localparam logic [ADDR_W-1:0] ADDR_EVENTS  = 12'd0;
  localparam logic [ADDR_W-1:0] ADDR_LEN     = 12'd4;
  localparam logic [ADDR_W-1:0] ADDR_DATA    = 12'd8;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

  localparam logic [WORD_W-1:0] SCREEN_WIDTH_RST  = 16'd320;
  localparam logic [WORD_W-1:0] SCREEN_HEIGHT_RST = 16'd480;

  // Event types and codes
  localparam logic [WORD_W-1:0] TYPE_SYN   = 16'd0;
  localparam logic [WORD_W-1:0] TYPE_KEY   = 16'd1;
  localparam logic [WORD_W-1:0] TYPE_ABS   = 16'd3;
  localparam logic [WORD_W-1:0] TYPE_SW    = 16'd5;
  localparam logic [WORD_W-1:0] CODE_TOUCH = 16'h014a;

  // Info pages
  localparam logic [15:0]       PAGE_EVBITS_HI = 16'h0001;
  localparam logic [DATA_W-1:0] PAGE_NAME      = 32'h0000_0000;
  localparam logic [DATA_W-1:0] PAGE_ABSDATA   = 32'h0002_0003;
  localparam logic [5:0]        NAME_LEN       = 6'd7;
  localparam logic [5:0]        KEYBITS_LEN    = 6'd42;
  localparam logic [5:0]        ABSDATA_LEN    = 6'd32;

  localparam int          KEYMAP_LEN = 57;
  localparam logic [14:0] ABS_MAX    = 15'h7fff;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_POP, ST_MUL, ST_DIV,
    ST_PUSH0, ST_PUSH1, ST_PUSH2, ST_FIN
  } state_t;

  // Datapath status toward the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            key_ok;
    logic            left;
    logic            pop_ok;
    logic            room;
  } dp_status_t;

  // Controller commands toward the datapath
  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       page_wr;
    logic       pop;
    logic       mul;
    logic       div;
    logic       push;
    logic [1:0] push_sel;
    logic       drop;
    logic       load_out;
  } dp_cmd_t;

  // Keymap: index to key code
  function automatic logic [WORD_W-1:0] keycode(input logic [KIDX_W-1:0] idx);
    logic [WORD_W-1:0] c;
    case (idx)
      6'd0: c = 16'd30;   6'd1: c = 16'd48;   6'd2: c = 16'd46;   6'd3: c = 16'd32;
      6'd4: c = 16'd18;   6'd5: c = 16'd33;   6'd6: c = 16'd34;   6'd7: c = 16'd35;
      6'd8: c = 16'd23;   6'd9: c = 16'd36;   6'd10: c = 16'd37;  6'd11: c = 16'd38;
      6'd12: c = 16'd50;  6'd13: c = 16'd49;  6'd14: c = 16'd24;  6'd15: c = 16'd25;
      6'd16: c = 16'd16;  6'd17: c = 16'd19;  6'd18: c = 16'd31;  6'd19: c = 16'd20;
      6'd20: c = 16'd22;  6'd21: c = 16'd47;  6'd22: c = 16'd17;  6'd23: c = 16'd45;
      6'd24: c = 16'd21;  6'd25: c = 16'd44;  6'd26: c = 16'd2;   6'd27: c = 16'd3;
      6'd28: c = 16'd4;   6'd29: c = 16'd5;   6'd30: c = 16'd6;   6'd31: c = 16'd7;
      6'd32: c = 16'd8;   6'd33: c = 16'd9;   6'd34: c = 16'd10;  6'd35: c = 16'd11;
      6'd36: c = 16'd28;  6'd37: c = 16'd14;  6'd38: c = 16'd57;  6'd39: c = 16'd15;
      6'd40: c = 16'd103; 6'd41: c = 16'd108; 6'd42: c = 16'd105; 6'd43: c = 16'd106;
      6'd44: c = 16'd42;  6'd45: c = 16'd54;  6'd46: c = 16'd29;  6'd47: c = 16'd97;
      6'd48: c = 16'd56;  6'd49: c = 16'd100; 6'd50: c = 16'd158; 6'd51: c = 16'd102;
      6'd52: c = 16'd139; 6'd53: c = 16'd116; 6'd54: c = 16'd115; 6'd55: c = 16'd114;
      6'd56: c = 16'd107;
      default: c = 16'd0;
    endcase
    return c;
  endfunction

  // Key capability bitmap: keymap codes plus send and touch
  function automatic logic [7:0] key_bits(input logic [ADDR_W-1:0] off);
    logic [7:0] b;
    case (off)
      12'd0:  b = 8'hfc;  12'd1:  b = 8'hcf;  12'd2:  b = 8'hff;  12'd3:  b = 8'hf3;
      12'd4:  b = 8'h7f;  12'd5:  b = 8'hf4;  12'd6:  b = 8'h47;  12'd7:  b = 8'h03;
      12'd12: b = 8'hd2;  12'd13: b = 8'h1e;  12'd14: b = 8'h1c;  12'd17: b = 8'h08;
      12'd19: b = 8'h40;  12'd28: b = 8'h80;  12'd41: b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Device name string
  function automatic logic [7:0] name_byte(input logic [2:0] off);
    logic [7:0] b;
    case (off)
      3'd0: b = 8'h71;  3'd1: b = 8'h77;  3'd2: b = 8'h65;  3'd3: b = 8'h72;
      3'd4: b = 8'h74;  3'd5: b = 8'h79;  3'd6: b = 8'h32;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Length in bytes of the selected page
  function automatic logic [5:0] page_len(input logic [DATA_W-1:0] page);
    logic [5:0] n;
    n = 6'd0;
    if (page == PAGE_NAME) begin
      n = NAME_LEN;
    end else if (page[31:16] == PAGE_EVBITS_HI) begin
      if (page[15:0] == TYPE_SYN || page[15:0] == TYPE_ABS || page[15:0] == TYPE_SW) begin
        n = 6'd1;
      end else if (page[15:0] == TYPE_KEY) begin
        n = KEYBITS_LEN;
      end
    end else if (page == PAGE_ABSDATA) begin
      n = ABSDATA_LEN;
    end
    return n;
  endfunction

  // One byte of the selected page; w_m1/h_m1 are the reported maxima
  function automatic logic [7:0] page_byte(input logic [DATA_W-1:0] page,
                                           input logic [ADDR_W-1:0] off,
                                           input logic [WORD_W-1:0] w_m1,
                                           input logic [WORD_W-1:0] h_m1);
    logic [7:0]        b;
    logic [WORD_W-1:0] v;
    b = 8'h00;
    v = '0;
    if (off < ADDR_W'(page_len(page))) begin
      if (page == PAGE_NAME) begin
        b = name_byte(off[2:0]);
      end else if (page[31:16] == PAGE_EVBITS_HI) begin
        if (page[15:0] == TYPE_KEY) begin
          b = key_bits(off);
        end else if (page[15:0] == TYPE_ABS) begin
          b = 8'h03;
        end else begin
          b = 8'h01;
        end
      end else begin
        if (off[4:2] == 3'd1) begin
          v = w_m1;
        end else if (off[4:2] == 3'd5) begin
          v = h_m1;
        end
        case (off[1:0])
          2'd0:    b = v[7:0];
          2'd1:    b = v[15:8];
          default: b = 8'h00;
        endcase
      end
    end
    return b;
  endfunction

  // Ring index advance with wrap
  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] i);
    return (i == RING_AW'(RING_WORDS - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

/* rtl/ieqd_if.sv */
// Channel interfaces: request items, result items and configuration writes.
`timescale 1ns / 1ps
interface ieqd_req_if;
  import ieqd_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] access_size;
  logic [DATA_W-1:0] write_data;
  logic [KIDX_W-1:0] key_index;
  logic              pressed;
  logic              button_left;
  logic              axis;
  logic [WORD_W-1:0] abs_value;
  modport source (output valid, operation, address, access_size, write_data, key_index,
                  pressed, button_left, axis, abs_value, input ready);
  modport sink (input valid, operation, address, access_size, write_data, key_index,
                pressed, button_left, axis, abs_value, output ready);
endinterface

interface ieqd_rsp_if;
  import ieqd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_level;
  logic              event_dropped;
  modport source (output valid, read_data, irq_level, event_dropped, input ready);
  modport sink (input valid, read_data, irq_level, event_dropped, output ready);
endinterface

interface ieqd_cfg_if;
  import ieqd_pkg::*;
  logic              valid;
  logic              ready;
  logic [0:0]        index;
  logic [WORD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/input_event_queue_device_unit.sv */
// Top level of the input event queue device: channels, controller and datapath.
//
//   channel  role    transfer carries
//   req      sink    operation, address, access_size, write_data, key_index,
//                    pressed, button_left, axis, abs_value
//   rsp      source  read_data, irq_level, event_dropped
//   cfg      sink    index (0 screen_width, 1 screen_height), data
//
// One item at a time: bus writes, reads and ignored events pass IDLE, EXEC and FIN;
// an event pop adds POP (ring RAM read), key, button and sync pushes PUSH0 to PUSH2
// (one ring write per word), abs events MUL (multiply), DIV (by 32767), then pushes.
// Synchronous reset empties the ring and selects the name page; the ring store itself
// is not cleared. A stalled result holds in the output register; the next item is
// taken meanwhile and waits only at its own result load. Configuration is always ready.
`timescale 1ns / 1ps
module input_event_queue_device_unit (
  input logic       clk,
  input logic       rst,
  ieqd_req_if.sink   req,
  ieqd_rsp_if.source rsp,
  ieqd_cfg_if.sink   cfg
);
  import ieqd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  ieqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ieqd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (req.operation),
    .address      (req.address),
    .access_size  (req.access_size),
    .write_data   (req.write_data),
    .key_index    (req.key_index),
    .pressed      (req.pressed),
    .button_left  (req.button_left),
    .axis         (req.axis),
    .abs_value    (req.abs_value),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .read_data    (rsp.read_data),
    .irq_level    (rsp.irq_level),
    .event_dropped(rsp.event_dropped)
  );
endmodule

/* rtl/ieqd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ieqd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/ieqd_dp.sv */
// Datapath: item latch, ring pointers, page logic, abs scaling and result register.
`timescale 1ns / 1ps
module ieqd_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ieqd_pkg::dp_cmd_t            cmd,
  output ieqd_pkg::dp_status_t         status,
  input  logic [ieqd_pkg::OP_W-1:0]    operation,
  input  logic [ieqd_pkg::ADDR_W-1:0]  address,
  input  logic [ieqd_pkg::SIZE_W-1:0]  access_size,
  input  logic [ieqd_pkg::DATA_W-1:0]  write_data,
  input  logic [ieqd_pkg::KIDX_W-1:0]  key_index,
  input  logic                         pressed,
  input  logic                         button_left,
  input  logic                         axis,
  input  logic [ieqd_pkg::WORD_W-1:0]  abs_value,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [ieqd_pkg::WORD_W-1:0]  cfg_data,
  output logic [ieqd_pkg::DATA_W-1:0]  read_data,
  output logic                         irq_level,
  output logic                         event_dropped
);
  import ieqd_pkg::*;

  // Latched item
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SIZE_W-1:0] size_q;
  logic [DATA_W-1:0] wdata_q;
  logic [KIDX_W-1:0] kidx_q;
  logic              pressed_q;
  logic              left_q;
  logic              axis_q;
  logic [WORD_W-1:0] absv_q;

  // Device state
  logic [DATA_W-1:0]  page_select;
  logic [WORD_W-1:0]  screen_width;
  logic [WORD_W-1:0]  screen_height;
  logic [RING_AW-1:0] ring_head;
  logic [RING_AW-1:0] ring_tail;
  logic [RING_CW-1:0] ring_count;

  // Working registers
  logic [DATA_W-1:0] rd_val;
  logic              use_q;
  logic [WORD_W-1:0] w_type;
  logic [WORD_W-1:0] w_code;
  logic [WORD_W-1:0] w_val;
  logic [30:0]       prod;
  logic              ext_zero;
  logic              drop;

  logic [WORD_W-1:0] ram_q;
  logic [WORD_W-1:0] push_word;

  // Status
  always_comb begin
    status.op     = op_q;
    status.key_ok = (kidx_q < KIDX_W'(KEYMAP_LEN));
    status.left   = left_q;
    status.pop_ok = (addr_q == ADDR_EVENTS) && (ring_count != '0);
    status.room   = ({1'b0, ring_count} + (RING_CW+1)'(3)) <= (RING_CW+1)'(RING_WORDS);
  end

  // Bus read value for everything but the event pop
  logic [SIZE_W-1:0]    size_n;
  logic [WIN_SUM_W-1:0] end_sum;
  logic                 in_win;
  logic [WORD_W-1:0]    w_m1;
  logic [WORD_W-1:0]    h_m1;
  logic [DATA_W-1:0]    bus_val;
  logic [ADDR_W-1:0]    lane_off [4];

  always_comb begin
    size_n  = (size_q > SIZE_W'(4)) ? SIZE_W'(4) : size_q;
    end_sum = WIN_SUM_W'(addr_q) + WIN_SUM_W'(size_n);
    in_win  = (addr_q >= ADDR_DATA) && (end_sum <= WIN_SUM_W'(WINDOW_BYTES));
    w_m1    = (screen_width == '0) ? '0 : screen_width - 1'b1;
    h_m1    = (screen_height == '0) ? '0 : screen_height - 1'b1;
    bus_val = '0;
    for (int i = 0; i < 4; i++) begin
      lane_off[i] = addr_q - ADDR_DATA + ADDR_W'(i);
    end
    if (addr_q == ADDR_LEN) begin
      bus_val = DATA_W'(page_len(page_select));
    end else if (in_win) begin
      for (int i = 0; i < 4; i++) begin
        if (SIZE_W'(i) < size_n) begin
          bus_val[8*i +: 8] = page_byte(page_select, lane_off[i], w_m1, h_m1);
        end
      end
    end
  end

  // Division of the scaled product by 32767
  logic [15:0] q0;
  logic [16:0] r1;
  logic [1:0]  q1;
  logic [15:0] r2;
  logic [15:0] quot;

  always_comb begin
    q0   = prod[30:15];
    r1   = 17'(prod[14:0]) + 17'(q0);
    q1   = r1[16:15];
    r2   = 16'(r1[14:0]) + 16'(q1);
    quot = q0 + 16'(q1) + 16'(r2 >= 16'(ABS_MAX));
  end

  // Multiply operands
  logic [WORD_W-1:0] ext_sel;
  logic [14:0]       abs_cl;

  always_comb begin
    ext_sel = axis_q ? screen_height : screen_width;
    abs_cl  = (absv_q > WORD_W'(ABS_MAX)) ? ABS_MAX : absv_q[14:0];
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= operation;
      addr_q    <= address;
      size_q    <= access_size;
      wdata_q   <= write_data;
      kidx_q    <= key_index;
      pressed_q <= pressed;
      left_q    <= button_left;
      axis_q    <= axis;
      absv_q    <= abs_value;
    end
  end

  // Configuration and page registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      page_select   <= PAGE_NAME;
    end else begin
      if (cfg_we && cfg_index == CFG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data;
      end
      if (cmd.page_wr && addr_q == ADDR_EVENTS) begin
        page_select <= wdata_q;
      end
    end
  end

  // Ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head  <= '0;
      ring_tail  <= '0;
      ring_count <= '0;
    end else if (cmd.pop) begin
      ring_head  <= ring_next(ring_head);
      ring_count <= ring_count - 1'b1;
    end else if (cmd.push) begin
      ring_tail <= ring_next(ring_tail);
      if (cmd.push_sel == 2'd2) begin
        ring_count <= ring_count + RING_CW'(3);
      end
    end
  end

  // Working registers: read value, triple words, scaling
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_val <= (op_q == OP_READ) ? bus_val : '0;
      use_q  <= (op_q == OP_READ) && (addr_q == ADDR_EVENTS) && (ring_count != '0);
      case (op_q)
        OP_KEY: begin
          w_type <= TYPE_KEY;
          w_code <= keycode(kidx_q);
          w_val  <= WORD_W'(pressed_q);
        end
        OP_BUTTON: begin
          w_type <= TYPE_KEY;
          w_code <= CODE_TOUCH;
          w_val  <= WORD_W'(pressed_q);
        end
        OP_ABS: begin
          w_type <= TYPE_ABS;
          w_code <= WORD_W'(axis_q);
          w_val  <= '0;
        end
        default: begin
          w_type <= TYPE_SYN;
          w_code <= '0;
          w_val  <= '0;
        end
      endcase
    end
    if (cmd.mul) begin
      prod     <= 31'(abs_cl) * 31'(ext_sel - 1'b1);
      ext_zero <= (ext_sel == '0);
    end
    if (cmd.div) begin
      w_val <= ext_zero ? '0 : quot;
    end
  end

  // Drop flag; a drop decided in the execute cycle wins over the clear
  always_ff @(posedge clk) begin
    if (rst) begin
      drop <= 1'b0;
    end else if (cmd.drop) begin
      drop <= 1'b1;
    end else if (cmd.exec) begin
      drop <= 1'b0;
    end
  end

  // Ring store
  always_comb begin
    case (cmd.push_sel)
      2'd0:    push_word = w_type;
      2'd1:    push_word = w_code;
      default: push_word = w_val;
    endcase
  end

  ieqd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(RING_WORDS)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(ring_tail),
    .wdata(push_word),
    .re   (cmd.pop),
    .raddr(ring_head),
    .rdata(ram_q)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data     <= use_q ? DATA_W'(ram_q) : rd_val;
      irq_level     <= (ring_count != '0);
      event_dropped <= drop;
    end
  end
endmodule

/* rtl/ieqd_ctrl.sv */
// Controller: sequences each item through the datapath and owns the handshakes.
`timescale 1ns / 1ps
module ieqd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ieqd_pkg::dp_status_t status,
  output ieqd_pkg::dp_cmd_t    cmd
);
  import ieqd_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_slot_free;

  assign out_slot_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_FIN;
        case (status.op)
          OP_READ: begin
            if (status.pop_ok) begin
              state_next = ST_POP;
            end
          end
          OP_WRITE: begin
            cmd.page_wr = 1'b1;
          end
          OP_KEY, OP_BUTTON, OP_SYNC: begin
            if ((status.op == OP_KEY && status.key_ok) ||
                (status.op == OP_BUTTON && status.left) ||
                status.op == OP_SYNC) begin
              if (status.room) begin
                state_next = ST_PUSH0;
              end else begin
                cmd.drop = 1'b1;
              end
            end
          end
          OP_ABS: begin
            state_next = ST_MUL;
          end
          default: begin
            state_next = ST_FIN;
          end
        endcase
      end
      ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = ST_FIN;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (status.room) begin
          state_next = ST_PUSH0;
        end else begin
          cmd.drop   = 1'b1;
          state_next = ST_FIN;
        end
      end
      ST_PUSH0: begin
        cmd.push     = 1'b1;
        cmd.push_sel = 2'd0;
        state_next   = ST_PUSH1;
      end
      ST_PUSH1: begin
        cmd.push     = 1'b1;
        cmd.push_sel = 2'd1;
        state_next   = ST_PUSH2;
      end
      ST_PUSH2: begin
        cmd.push     = 1'b1;
        cmd.push_sel = 2'd2;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        if (out_slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the input event queue device: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_top;
  import ieqd_pkg::*;

  // One request item and one result item
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] wdata;
    logic [KIDX_W-1:0] kidx;
    logic              pressed;
    logic              left;
    logic              axis;
    logic [WORD_W-1:0] absv;
  } dev_req_t;

  typedef struct {
    logic [DATA_W-1:0] rdata;
    logic              irq;
    logic              dropped;
  } dev_rsp_t;

  // Directed row: typed-in read data is used where fixed is set
  typedef struct {
    dev_req_t          it;
    bit                fixed;
    logic [DATA_W-1:0] rdata;
  } dir_row_t;

  localparam int KEYMAP_N    = 57;
  localparam int SETTLE      = 20;
  localparam int HOLD_OFF    = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 178;

  localparam int KEY_CODES [KEYMAP_N] = '{
    30, 48, 46, 32, 18, 33, 34, 35, 23, 36, 37, 38, 50, 49, 24, 25, 16, 19,
    31, 20, 22, 47, 17, 45, 21, 44, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11,
    28, 14, 57, 15, 103, 108, 105, 106, 42, 54, 29, 97, 56, 100,
    158, 102, 139, 116, 115, 114, 107
  };
  localparam logic [7:0] DEV_NAME [7] = '{8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h32};
  localparam logic [15:0] CODE_SEND = 16'd231;

  logic clk;
  logic rst;

  ieqd_req_if req ();
  ieqd_rsp_if rsp ();
  ieqd_cfg_if cfg ();

  input_event_queue_device_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  // Shadow device state
  logic [WORD_W-1:0] shadow_ring [$];
  logic [DATA_W-1:0] shadow_page;
  logic [WORD_W-1:0] shadow_width;
  logic [WORD_W-1:0] shadow_height;
  bit                key_supported [0:511];

  // Outstanding results
  dev_rsp_t pending_rsp [$];

  // Sideband carried with the item on the wire
  bit                row_fixed;
  logic [DATA_W-1:0] row_rdata;

  int  err_count;
  int  items_sent;
  int  drops_seen;
  int  pops_seen;
  int  idle_cycles;
  bit  hold_off_req;

  always #1 clk = ~clk;

  // Capability page helpers
  function automatic int info_len();
    logic [15:0] t;
    t = shadow_page[15:0];
    if (shadow_page == 32'h0) return 7;
    if (shadow_page[31:16] == 16'h0001) begin
      if (t == TYPE_SYN || t == TYPE_ABS || t == TYPE_SW) return 1;
      if (t == TYPE_KEY) return CODE_TOUCH / 8 + 1;
      return 0;
    end
    if (shadow_page == PAGE_ABSDATA) return 32;
    return 0;
  endfunction

  function automatic logic [7:0] info_byte(int off);
    logic [15:0] t;
    logic [7:0]  bits;
    logic [31:0] v;
    t = shadow_page[15:0];
    bits = 8'h00;
    v = '0;
    if (off >= info_len()) return 8'h00;
    if (shadow_page == 32'h0) return DEV_NAME[off];
    if (shadow_page[31:16] == 16'h0001) begin
      for (int b = 0; b < 8; b++) begin
        if ((t == TYPE_SYN || t == TYPE_SW) && off * 8 + b == 0) bits[b] = 1'b1;
        if (t == TYPE_ABS && off * 8 + b <= 1) bits[b] = 1'b1;
        if (t == TYPE_KEY && key_supported[off * 8 + b]) bits[b] = 1'b1;
      end
      return bits;
    end
    if (off / 4 == 1) v = (shadow_width != 0) ? shadow_width - 1 : 0;
    else if (off / 4 == 5) v = (shadow_height != 0) ? shadow_height - 1 : 0;
    return v[(off % 4) * 8 +: 8];
  endfunction

  function automatic logic [15:0] scaled_pos(logic [15:0] raw, logic [15:0] extent);
    logic [63:0] p;
    if (extent == 0) return 16'h0;
    p = (raw > 16'h7fff) ? 64'h7fff : 64'(raw);
    p = p * (64'(extent) - 1) / 64'h7fff;
    return p[15:0];
  endfunction

  // Push one event triple; returns 1 when there is no room
  function automatic bit push_event(logic [15:0] ty, logic [15:0] code, logic [15:0] val);
    if (shadow_ring.size() + 3 > RING_WORDS) return 1'b1;
    shadow_ring.push_back(ty);
    shadow_ring.push_back(code);
    shadow_ring.push_back(val);
    return 1'b0;
  endfunction

  // Expected result of one item; updates the shadow state
  function automatic dev_rsp_t device_result(dev_req_t r);
    dev_rsp_t o;
    int       n;
    o.rdata = '0;
    o.dropped = 1'b0;
    case (r.op)
      OP_READ: begin
        n = (r.size > 4) ? 4 : int'(r.size);
        if (r.addr == ADDR_EVENTS) begin
          if (shadow_ring.size() != 0) o.rdata = 32'(shadow_ring.pop_front());
        end else if (r.addr == ADDR_LEN) begin
          o.rdata = 32'(info_len());
        end else if (r.addr >= ADDR_DATA && int'(r.addr) + n <= WINDOW_BYTES) begin
          for (int i = 0; i < n; i++) o.rdata[8 * i +: 8] = info_byte(int'(r.addr) - 8 + i);
        end
      end
      OP_WRITE: if (r.addr == ADDR_EVENTS) shadow_page = r.wdata;
      OP_KEY: if (r.kidx < KEYMAP_N)
        o.dropped = push_event(TYPE_KEY, 16'(KEY_CODES[r.kidx]), 16'(r.pressed));
      OP_BUTTON: if (r.left) o.dropped = push_event(TYPE_KEY, CODE_TOUCH, 16'(r.pressed));
      OP_ABS: begin
        if (!r.axis) o.dropped = push_event(TYPE_ABS, 16'd0, scaled_pos(r.absv, shadow_width));
        else o.dropped = push_event(TYPE_ABS, 16'd1, scaled_pos(r.absv, shadow_height));
      end
      OP_SYNC: o.dropped = push_event(TYPE_SYN, 16'd0, 16'd0);
      default: ;
    endcase
    o.irq = (shadow_ring.size() != 0);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb_top: mismatch %s got 0x%08h want 0x%08h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Acceptance monitor: predict on request transfer, check on result transfer
  always @(posedge clk) begin
    dev_rsp_t e;
    dev_rsp_t g;
    bit       moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_SCREEN_WIDTH) shadow_width = cfg.data;
        else shadow_height = cfg.data;
      end
      if (req.valid && req.ready) begin
        moved = 1'b1;
        e = device_result('{req.operation, req.address, req.access_size, req.write_data,
                            req.key_index, req.pressed, req.button_left, req.axis,
                            req.abs_value});
        if (row_fixed) begin
          e.rdata = row_rdata;
          e.dropped = 1'b0;
        end
        pending_rsp.push_back(e);
      end
      if (rsp.valid && rsp.ready) begin
        moved = 1'b1;
        g = '{rsp.read_data, rsp.irq_level, rsp.event_dropped};
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result", g.rdata, 32'h0);
        end else begin
          e = pending_rsp.pop_front();
          if (g.rdata !== e.rdata) report_mismatch("read_data", g.rdata, e.rdata);
          if (g.irq !== e.irq) report_mismatch("irq_level", 32'(g.irq), 32'(e.irq));
          if (g.dropped !== e.dropped)
            report_mismatch("event_dropped", 32'(g.dropped), 32'(e.dropped));
          if (g.dropped === 1'b1) drops_seen++;
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int seg;
    int mode;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        seg = $urandom_range(1, 24);
        mode = $urandom_range(0, 3);
        repeat (seg) begin
          case (mode)
            0, 1: rsp.ready <= 1'b1;
            2: rsp.ready <= 1'($urandom_range(0, 1));
            default: rsp.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Sender: bursts of random length with random gaps
  int burst_left;

  task automatic send_item(dev_req_t it, bit fixed, logic [31:0] rdata);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid       <= 1'b1;
    req.operation   <= it.op;
    req.address     <= it.addr;
    req.access_size <= it.size;
    req.write_data  <= it.wdata;
    req.key_index   <= it.kidx;
    req.pressed     <= it.pressed;
    req.button_left <= it.left;
    req.axis        <= it.axis;
    req.abs_value   <= it.absv;
    row_fixed       <= fixed;
    row_rdata       <= rdata;
    do @(posedge clk); while (!req.ready);
    items_sent++;
    if (it.op == OP_READ && it.addr == ADDR_EVENTS) pops_seen++;
  endtask

  // Wait until every result is in, then let the block settle
  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  function automatic dev_req_t mk(logic [2:0] op, logic [11:0] addr, logic [2:0] size,
                                  logic [31:0] wdata, logic [5:0] kidx, logic pressed,
                                  logic left, logic axis, logic [15:0] absv);
    return '{op, addr, size, wdata, kidx, pressed, left, axis, absv};
  endfunction

  function automatic logic [31:0] pick_page();
    case ($urandom_range(0, 5))
      0: return PAGE_NAME;
      1: return PAGE_ABSDATA;
      2, 3: return {16'h0001, 16'($urandom_range(0, 6))};
      4: return {16'h0001, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Random item; style 0 mixed, 1 events and unknown ops only, 2 mostly pops
  function automatic dev_req_t random_item(int style);
    dev_req_t r;
    int       w;
    r = mk(3'($urandom_range(0, 7)), 12'($urandom), 3'($urandom_range(0, 7)), $urandom,
           ($urandom_range(0, 9) == 0) ? 6'($urandom_range(57, 63)) : 6'($urandom_range(0, 56)),
           1'($urandom), 1'($urandom_range(0, 4) != 0), 1'($urandom), 16'($urandom));
    w = $urandom_range(0, 99);
    case (style)
      1: r.op = (w < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(2, 5));
      2: r.op = (w < 70) ? OP_READ : (w < 80) ? OP_WRITE : 3'($urandom_range(2, 7));
      default: r.op = (w < 35) ? OP_READ : (w < 45) ? OP_WRITE : 3'($urandom_range(2, 7));
    endcase
    if (r.op == OP_READ) begin
      w = $urandom_range(0, 99);
      if (style == 2 && w < 80) r.addr = ADDR_EVENTS;
      else if (w < 30) r.addr = ADDR_EVENTS;
      else if (w < 45) r.addr = ADDR_LEN;
      else if (w < 80) r.addr = 12'($urandom_range(8, 56));
      else if (w < 90) r.addr = 12'($urandom_range(4088, 4095));
    end else if (r.op == OP_WRITE) begin
      if ($urandom_range(0, 4) != 0) r.addr = ADDR_EVENTS;
      r.wdata = pick_page();
    end
    return r;
  endfunction

  // Main sequence
  initial begin
    dir_row_t    rows [$];
    logic [15:0] wv;
    logic [15:0] hv;
    clk = 1'b0;
    rst = 1'b1;
    err_count = 0;
    items_sent = 0;
    drops_seen = 0;
    pops_seen = 0;
    idle_cycles = 0;
    hold_off_req = 1'b0;
    burst_left = 0;
    row_fixed = 1'b0;
    row_rdata = '0;
    shadow_page = '0;
    shadow_width = SCREEN_WIDTH_RST;
    shadow_height = SCREEN_HEIGHT_RST;
    for (int i = 0; i < 512; i++) key_supported[i] = 1'b0;
    foreach (KEY_CODES[i]) key_supported[KEY_CODES[i]] = 1'b1;
    key_supported[CODE_SEND] = 1'b1;
    key_supported[CODE_TOUCH] = 1'b1;
    req.valid <= 1'b0;
    req.operation <= OP_READ;
    req.address <= '0;
    req.access_size <= '0;
    req.write_data <= '0;
    req.key_index <= '0;
    req.pressed <= 1'b0;
    req.button_left <= 1'b0;
    req.axis <= 1'b0;
    req.abs_value <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_SCREEN_WIDTH;
    cfg.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: register window after reset, extremes and ignored cases
    rows.push_back('{mk(OP_READ, ADDR_LEN, 3'd4, 0, 0, 0, 0, 0, 0), 1, 32'd7});
    rows.push_back('{mk(OP_READ, ADDR_EVENTS, 3'd4, 0, 0, 0, 0, 0, 0), 1, 32'd0});
    rows.push_back('{mk(OP_READ, 12'd8, 3'd4, 0, 0, 0, 0, 0, 0), 1, 32'h7265_7771});
    rows.push_back('{mk(OP_READ, 12'd12, 3'd7, 0, 0, 0, 0, 0, 0), 1, 32'h0032_7974});
    rows.push_back('{mk(OP_READ, 12'd4094, 3'd4, 0, 0, 0, 0, 0, 0), 1, 32'd0});
    rows.push_back('{mk(OP_READ, 12'd8, 3'd0, 0, 0, 0, 0, 0, 0), 1, 32'd0});
    rows.push_back('{mk(OP_READ, 12'd2, 3'd4, 0, 0, 0, 0, 0, 0), 1, 32'd0});
    rows.push_back('{mk(3'd6, 12'hfff, 3'd7, '1, '1, 1, 1, 1, '1), 1, 32'd0});
    rows.push_back('{mk(3'd7, 12'd0, 3'd1, 0, 0, 0, 0, 0, 0), 1, 32'd0});
    rows.push_back('{mk(OP_KEY, 0, 1, 0, 6'd0, 1, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_KEY, 0, 1, 0, 6'd63, 1, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_KEY, 0, 1, 0, 6'd56, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_BUTTON, 0, 1, 0, 0, 1, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_BUTTON, 0, 1, 0, 0, 1, 1, 0, 0), 0, 0});
    rows.push_back('{mk(OP_ABS, 0, 1, 0, 0, 0, 0, 0, 16'hffff), 0, 0});
    rows.push_back('{mk(OP_ABS, 0, 1, 0, 0, 0, 0, 1, 16'h0000), 0, 0});
    rows.push_back('{mk(OP_SYNC, 0, 1, 0, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_WRITE, ADDR_LEN, 4, 32'h0001_0001, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_READ, ADDR_LEN, 1, 0, 0, 0, 0, 0, 0), 1, 32'd7});
    rows.push_back('{mk(OP_WRITE, ADDR_EVENTS, 4, 32'h0001_0001, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_READ, ADDR_LEN, 2, 0, 0, 0, 0, 0, 0), 1, 32'd42});
    rows.push_back('{mk(OP_WRITE, ADDR_EVENTS, 4, PAGE_ABSDATA, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk(OP_READ, 12'd12, 4, 0, 0, 0, 0, 0, 0), 1, 32'd319});
    rows.push_back('{mk(OP_READ, 12'd28, 4, 0, 0, 0, 0, 0, 0), 1, 32'd479});
    rows.push_back('{mk(OP_WRITE, ADDR_EVENTS, 4, 32'hffff_ffff, 0, 0, 0, 0, 0), 0, 0});
    foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].rdata);
    drain_results();

    // Random phases; registers change only while idle
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin wv = 16'd0; hv = 16'd0; end
        1: begin wv = 16'd1; hv = 16'd1; end
        2: begin wv = 16'hffff; hv = 16'hffff; end
        3: begin wv = SCREEN_WIDTH_RST; hv = SCREEN_HEIGHT_RST; end
        default: begin wv = 16'($urandom); hv = 16'($urandom); end
      endcase
      write_reg(CFG_SCREEN_WIDTH, wv);
      write_reg(CFG_SCREEN_HEIGHT, hv);
      // Phases 2 and 3 send events and unknown ops only, so the ring fills and drops; phase 4 mostly pops
      if (p == 3) hold_off_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_item(random_item((p == 2 || p == 3) ? 1 : (p == 4) ? 2 : 0), 1'b0, '0);
      end
      drain_results();
    end

    $display("tb_top: %0d items sent, %0d event pops, %0d dropped triples seen",
             items_sent, pops_seen, drops_seen);
    $display("tb_top: covered all pages, ring overflow, long result stall, %0d settings",
             PHASES + 1);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ieqd_pkg.sv
rtl/ieqd_if.sv
rtl/ieqd_ram.sv
rtl/ieqd_dp.sv
rtl/ieqd_ctrl.sv
rtl/input_event_queue_device_unit.sv
tb/tb_top.sv
